@@ src/joint_settle_watchdog_core_assert.svh @@
// Assertion macros shared by the settle watchdog RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef JOINT_SETTLE_WATCHDOG_CORE_ASSERT_SVH
`define JOINT_SETTLE_WATCHDOG_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JSW_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSW_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ src/jsw_pkg.sv @@
// Shared types, codes and helpers for the joint settle watchdog.
// No dependencies; used by jsw_peak and joint_settle_watchdog_core.
package jsw_pkg;

    localparam int JOINT_COUNT = 6;
    localparam int ANGLE_BITS  = 20;
    localparam int MOVE_BITS   = 19;
    localparam int TICK_BITS   = 16;
    localparam int STILL_BITS  = 4;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;

    typedef logic [ANGLE_BITS-1:0]    angle_t;
    typedef angle_t [JOINT_COUNT-1:0] angle_vec_t;
    typedef logic [ANGLE_BITS-1:0]    mag_t;

    typedef enum logic [1:0] {
        KIND_LOAD_TARGET = 2'd0,
        KIND_LOAD_REF    = 2'd1,
        KIND_TICK        = 2'd2,
        KIND_UNUSED      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_WAIT    = 2'd0,
        STATUS_REACHED = 2'd1,
        STATUS_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_MOVE_THR  = 3'd0,
        REG_ERR_THR   = 3'd1,
        REG_MASK      = 3'd2,
        REG_TIMEOUT   = 3'd3,
        REG_STILL_REQ = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] kind;
        angle_t     joint_0;
        angle_t     joint_1;
        angle_t     joint_2;
        angle_t     joint_3;
        angle_t     joint_4;
        angle_t     joint_5;
    } in_word_t;

    typedef struct packed {
        logic [1:0]            status;
        mag_t                  peak_error;
        mag_t                  peak_movement;
        logic [STILL_BITS-1:0] still_count;
    } out_word_t;

    typedef struct packed {
        mag_t peak_error;
        mag_t peak_movement;
    } peaks_t;

    // |a - b| of two signed angles; the magnitude always fits ANGLE_BITS.
    function automatic mag_t abs_diff(angle_t a, angle_t b);
        logic signed [ANGLE_BITS:0] d;
        logic        [ANGLE_BITS:0] m;
        d = $signed({a[ANGLE_BITS-1], a}) - $signed({b[ANGLE_BITS-1], b});
        m = d[ANGLE_BITS] ? (~d + 1'b1) : d;
        return m[ANGLE_BITS-1:0];
    endfunction

endpackage

@@ src/jsw_peak.sv @@
// Peak error and peak movement over all joints for one sample.
// Depends on jsw_pkg (angle types, abs_diff, peaks_t).
module jsw_peak
    import jsw_pkg::*;
(
    input  angle_vec_t cur,
    input  angle_vec_t target,
    input  angle_vec_t prev,
    output peaks_t     peaks
);

    always_comb
    begin
        mag_t err;
        mag_t mov;
        peaks.peak_error    = '0;
        peaks.peak_movement = '0;
        for (int j = 0; j < JOINT_COUNT; j++)
        begin
            err = abs_diff(cur[j], target[j]);
            mov = abs_diff(cur[j], prev[j]);
            if (err > peaks.peak_error)
            begin
                peaks.peak_error = err;
            end
            if (mov > peaks.peak_movement)
            begin
                peaks.peak_movement = mov;
            end
        end
    end

endmodule

@@ src/joint_settle_watchdog_core.sv @@
// Top level of the joint settle watchdog: input stage, tick logic, result word, APB registers.
// Depends on jsw_pkg, jsw_peak and joint_settle_watchdog_core_assert.svh.
//
// Usage:
//   item/item_valid/item_ready carry input words: a load-target word stores the six target
//   angles and restarts the watchdog, a load-reference word stores the starting angles,
//   a tick word carries the current angles. Every accepted word yields exactly one result
//   word on result/result_valid/result_ready (status, peak error, peak movement, still
//   count). An accepted word is first registered in the input stage, then the peak and
//   counter logic fills the result register. Throughput is one word per cycle while
//   result_ready is high; the input stage and result register form a two-deep pipeline,
//   so a new word is taken while a finished result waits. When the receiver stalls, the
//   result holds and the input stage fills; item_ready drops only once both are full.
//   Reset clears the counters, the status (waiting) and both valid flags, and loads the
//   register defaults; target and reference angles are undefined until loaded.
//   The APB port (pready always high) writes the five thresholds at byte address 4*i;
//   write it only while no word is in flight.
module joint_settle_watchdog_core
    import jsw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  in_word_t          item,
    output logic              result_valid,
    input  logic              result_ready,
    output out_word_t         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

`include "joint_settle_watchdog_core_assert.svh"

    // Configuration registers.
    logic [MOVE_BITS-1:0]  move_thr_reg;
    logic [MOVE_BITS-1:0]  err_thr_reg;
    logic [TICK_BITS-1:0]  mask_reg;
    logic [TICK_BITS-1:0]  timeout_reg;
    logic [STILL_BITS-1:0] still_req_reg;

    // Pipeline registers.
    logic      stage_valid_reg;
    in_word_t  stage_reg;
    logic      res_valid_reg;
    out_word_t res_reg;

    // Watchdog state.
    angle_vec_t            target_reg;
    angle_vec_t            prev_reg;
    logic [STILL_BITS-1:0] still_reg;
    logic [STILL_BITS-1:0] still_next;
    logic [TICK_BITS-1:0]  tick_reg;
    logic [TICK_BITS-1:0]  tick_next;
    status_t               status_reg;
    status_t               status_next;

    logic       adv;
    logic       fire;
    logic       cfg_wr;
    reg_idx_t   cfg_idx;
    angle_vec_t cur;
    peaks_t     peaks;
    out_word_t  res_next;

    // ---------------------------------------------------------------- APB
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_thr_reg  <= MOVE_BITS'(33);
            err_thr_reg   <= MOVE_BITS'(6554);
            mask_reg      <= TICK_BITS'(2);
            timeout_reg   <= TICK_BITS'(100);
            still_req_reg <= STILL_BITS'(3);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MOVE_THR:  move_thr_reg  <= pwdata[MOVE_BITS-1:0];
                REG_ERR_THR:   err_thr_reg   <= pwdata[MOVE_BITS-1:0];
                REG_MASK:      mask_reg      <= pwdata[TICK_BITS-1:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata[TICK_BITS-1:0];
                REG_STILL_REQ: still_req_reg <= pwdata[STILL_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MOVE_THR:  prdata = APB_DW'(move_thr_reg);
            REG_ERR_THR:   prdata = APB_DW'(err_thr_reg);
            REG_MASK:      prdata = APB_DW'(mask_reg);
            REG_TIMEOUT:   prdata = APB_DW'(timeout_reg);
            REG_STILL_REQ: prdata = APB_DW'(still_req_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- handshake
    // Advance the stage word whenever the result register is empty or being drained.
    assign adv        = !res_valid_reg || result_ready;
    assign fire       = stage_valid_reg && adv;
    assign item_ready = !stage_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end
            if (adv)
            begin
                res_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_reg <= item;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // ---------------------------------------------------------------- tick logic
    assign cur = {stage_reg.joint_5, stage_reg.joint_4, stage_reg.joint_3,
                  stage_reg.joint_2, stage_reg.joint_1, stage_reg.joint_0};

    jsw_peak u_peak (
        .cur    (cur),
        .target (target_reg),
        .prev   (prev_reg),
        .peaks  (peaks)
    );

    always_comb
    begin
        still_next  = still_reg;
        tick_next   = tick_reg;
        status_next = status_reg;
        res_next.peak_error    = '0;
        res_next.peak_movement = '0;
        unique case (kind_t'(stage_reg.kind))
            KIND_LOAD_TARGET:
            begin
                still_next  = '0;
                tick_next   = '0;
                status_next = STATUS_WAIT;
            end
            KIND_TICK:
            begin
                res_next.peak_error    = peaks.peak_error;
                res_next.peak_movement = peaks.peak_movement;
                // Counters and status only move while waiting; freeze once final.
                if (status_reg == STATUS_WAIT)
                begin
                    if (peaks.peak_movement < ANGLE_BITS'(move_thr_reg))
                    begin
                        if (still_reg != '1)
                        begin
                            still_next = still_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        still_next = '0;
                    end
                    if (tick_reg > mask_reg &&
                        peaks.peak_error < ANGLE_BITS'(err_thr_reg) &&
                        still_next >= still_req_reg)
                    begin
                        status_next = STATUS_REACHED;
                    end
                    else
                    begin
                        if (tick_reg != '1)
                        begin
                            tick_next = tick_reg + 1'b1;
                        end
                        if (tick_next >= timeout_reg)
                        begin
                            status_next = STATUS_TIMEOUT;
                        end
                    end
                end
            end
            default: ;
        endcase
        res_next.status      = status_next;
        res_next.still_count = still_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            still_reg  <= '0;
            tick_reg   <= '0;
            status_reg <= STATUS_WAIT;
        end
        else if (fire)
        begin
            still_reg  <= still_next;
            tick_reg   <= tick_next;
            status_reg <= status_next;
        end
    end

    // Angle stores: load target, load reference; every tick refreshes the previous sample.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (kind_t'(stage_reg.kind) == KIND_LOAD_TARGET)
            begin
                target_reg <= cur;
            end
            if (kind_t'(stage_reg.kind) == KIND_LOAD_REF ||
                kind_t'(stage_reg.kind) == KIND_TICK)
            begin
                prev_reg <= cur;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // ---------------------------------------------------------------- checks
    `JSW_ASSERT_NEXT(a_final_holds,
        status_reg != STATUS_WAIT &&
        !(fire && kind_t'(stage_reg.kind) == KIND_LOAD_TARGET),
        status_reg == $past(status_reg), "final status changed without a target load")
    `JSW_ASSERT_NEXT(a_load_restarts, fire && kind_t'(stage_reg.kind) == KIND_LOAD_TARGET,
        tick_reg == '0 && still_reg == '0 && status_reg == STATUS_WAIT,
        "target load did not restart the watchdog")
    `JSW_ASSERT_NEXT(a_state_idle, !fire,
        $stable(tick_reg) && $stable(still_reg) && $stable(status_reg),
        "watchdog state moved without a word")
    `JSW_ASSERT_NEXT(a_stage_kept, stage_valid_reg && !adv, stage_valid_reg,
        "stalled stage word was dropped")

endmodule
